[rtl/core/lfr_pkg.sv]
// Shared types and constants for the link frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package lfr_pkg;

  // Line bytes
  localparam logic [7:0] FLAG_BYTE = 8'h5c;
  localparam logic [7:0] ESC_BYTE  = 8'h5d;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // Control bytes seen in headers
  localparam logic [7:0] CTL_I0   = 8'h00;
  localparam logic [7:0] CTL_I1   = 8'h02;
  localparam logic [7:0] CTL_SET  = 8'h03;
  localparam logic [7:0] CTL_UA   = 8'h07;
  localparam logic [7:0] CTL_DISC = 8'h0B;

  // Reply control bytes
  localparam logic [7:0] CTL_RR0  = 8'h01;
  localparam logic [7:0] CTL_RR1  = 8'h21;
  localparam logic [7:0] CTL_REJ0 = 8'h05;
  localparam logic [7:0] CTL_REJ1 = 8'h25;

  // Result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_VERDICT = 2'd1;
  localparam logic [1:0] KIND_FAIL    = 2'd2;

  // Verdict codes
  localparam logic [2:0] VERD_NEW  = 3'd0;
  localparam logic [2:0] VERD_DUP  = 3'd1;
  localparam logic [2:0] VERD_BAD  = 3'd2;
  localparam logic [2:0] VERD_SET  = 3'd3;
  localparam logic [2:0] VERD_UA   = 3'd4;
  localparam logic [2:0] VERD_DISC = 3'd5;

  // Input item modes
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Configuration register indexes
  localparam logic REG_MAX_TRIES = 1'b0;
  localparam logic REG_STATION   = 1'b1;

  localparam logic [7:0] MAX_TRIES_RESET = 8'd3;
  localparam logic [7:0] STATION_RESET   = 8'd1;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [2:0] verdict;
    logic       reply_valid;
    logic [7:0] reply_control;
    logic       last;
  } result_t;

  // One queue entry: the one or two results caused by one input item
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage : lfr_pkg
`default_nettype wire

[rtl/core/link_frame_receiver_arq_core.sv]
// Top level of the link frame receiver: register port, front end, queue and back end.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-------------------------------
//  item      | in        | push / full            | mode, rx_byte
//  result    | out       | empty / pop            | kind, data_byte, verdict,
//            |           |                        | reply_valid, reply_control, last
//  registers | in/out    | psel penable pwrite    | paddr 0: max_tries, 4: station
//
//  One item is taken every cycle while the queue has room; the front end
//  finishes it in the cycle of its transfer and writes its one or two results
//  as a single queue entry at the transfer edge. The back end loads the output
//  register from the queue, no earlier than the edge after the transfer edge,
//  once that register is empty or being popped. Results leave at one per cycle
//  while pop is high, so an item with two results takes longer to leave than
//  to enter; the QUEUE_DEPTH-entry queue soaks up the difference, and full is
//  high whenever all its entries are taken, even in a cycle where one leaves.
//  Synchronous reset clears the hunt state, queue and output register and
//  sets max_tries to 3 and the station address to 1.
//
module link_frame_receiver_arq_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // item side
  input  wire logic              push,
  output logic                   full,
  input  wire lfr_pkg::item_t    item,
  // result side
  output logic                   empty,
  input  wire logic              pop,
  output lfr_pkg::result_t       result,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import lfr_pkg::*;

  logic       accept;
  logic [7:0] max_tries, station_address;
  logic       cfg_wr;

  logic       q_wr, q_rd;
  entry_t     q_wr_entry, q_rd_entry;
  q_status_t  q_stat;

  // Register port: zero wait states, word select on paddr bit 2
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tries       <= MAX_TRIES_RESET;
      station_address <= STATION_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_TRIES) begin
        max_tries <= pwdata[7:0];
      end else begin
        station_address <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_STATION) ? {24'd0, station_address}
                                            : {24'd0, max_tries};

  // Transfer on the item side whenever the queue has room
  assign full   = q_stat.full;
  assign accept = push && !full;

  lfr_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .item            (item),
    .max_tries       (max_tries),
    .station_address (station_address),
    .q_wr            (q_wr),
    .q_entry         (q_wr_entry)
  );

  lfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_entry (q_wr_entry),
    .rd       (q_rd),
    .rd_entry (q_rd_entry),
    .stat     (q_stat)
  );

  lfr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .q_entry (q_rd_entry),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule : link_frame_receiver_arq_core
`default_nettype wire

[rtl/core/lfr_front.sv]
// Front end: header hunt, destuffing, byte hold and verdicts for each accepted item.
`timescale 1ns / 1ps
`default_nettype none
module lfr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire lfr_pkg::item_t item,
  input  wire logic [7:0]    max_tries,
  input  wire logic [7:0]    station_address,
  output logic               q_wr,
  output lfr_pkg::entry_t    q_entry
);
  import lfr_pkg::*;

  typedef enum logic [2:0] {
    ST_WAIT  = 3'd0,
    ST_FLAG  = 3'd1,
    ST_ADDR  = 3'd2,
    ST_CTRL  = 3'd3,
    ST_DATA0 = 3'd4,
    ST_SUPV  = 3'd5,
    ST_DATA1 = 3'd6
  } hunt_t;

  hunt_t      hunt, hunt_next;
  logic [7:0] control_seen, control_seen_next;
  logic       esc, esc_next;
  logic [7:0] held, held_next;
  logic       held_valid, held_valid_next;
  logic [7:0] chk, chk_next;
  logic       exp_seq, exp_seq_next;
  logic [7:0] tcount, tcount_next;

  result_t    res [2];
  logic [1:0] n;
  logic [7:0] b, p0, p1, t;
  logic       p0v, p1v, closing, ns, good;

  function automatic result_t mk_result(logic [1:0] kind, logic [7:0] data,
                                        logic [2:0] verd, logic rv, logic [7:0] rc);
    result_t r;
    r.kind          = kind;
    r.data_byte     = data;
    r.verdict       = verd;
    r.reply_valid   = rv;
    r.reply_control = rc;
    r.last          = 1'b0;
    return r;
  endfunction

  always_comb begin
    hunt_next         = hunt;
    control_seen_next = control_seen;
    esc_next          = esc;
    held_next         = held;
    held_valid_next   = held_valid;
    chk_next          = chk;
    exp_seq_next      = exp_seq;
    tcount_next       = tcount;
    res[0]  = '0;
    res[1]  = '0;
    n       = 2'd0;
    b       = item.rx_byte;
    p0      = '0;
    p1      = '0;
    p0v     = 1'b0;
    p1v     = 1'b0;
    closing = 1'b0;
    ns      = 1'b0;
    good    = 1'b0;
    t       = tcount + 8'd1;

    if (item.mode == MODE_TICK) begin
      // drop any partial frame and count the tick
      hunt_next       = ST_WAIT;
      esc_next        = 1'b0;
      held_next       = '0;
      held_valid_next = 1'b0;
      chk_next        = '0;
      if (t >= max_tries) begin
        tcount_next = '0;
        res[0]      = mk_result(KIND_FAIL, 8'd0, VERD_NEW, 1'b0, 8'd0);
        n           = 2'd1;
      end else begin
        tcount_next = t;
      end
    end else begin
      case (hunt)
        ST_FLAG: begin
          if (b == station_address) begin
            hunt_next = ST_ADDR;
          end else if (b != FLAG_BYTE) begin
            hunt_next = ST_WAIT;
          end
        end
        ST_ADDR: begin
          if (b == CTL_I0 || b == CTL_I1 || b == CTL_SET || b == CTL_UA || b == CTL_DISC) begin
            control_seen_next = b;
            hunt_next         = ST_CTRL;
          end else begin
            hunt_next = (b == FLAG_BYTE) ? ST_FLAG : ST_WAIT;
          end
        end
        ST_CTRL: begin
          if (b == (station_address ^ control_seen)) begin
            esc_next        = 1'b0;
            held_next       = '0;
            held_valid_next = 1'b0;
            chk_next        = '0;
            hunt_next = (control_seen == CTL_I0 || control_seen == CTL_I1) ? ST_DATA0 : ST_SUPV;
          end else begin
            hunt_next = (b == FLAG_BYTE) ? ST_FLAG : ST_WAIT;
          end
        end
        ST_DATA0, ST_DATA1: begin
          if (b == FLAG_BYTE) begin
            closing = 1'b1;
            if (esc) begin
              // a dangling escape goes out as a literal
              esc_next = 1'b0;
              p0v      = 1'b1;
              p0       = ESC_BYTE;
            end
          end else if (esc) begin
            esc_next = 1'b0;
            if (b == (FLAG_BYTE ^ ESC_XOR)) begin
              p0v = 1'b1;
              p0  = FLAG_BYTE;
            end else if (b == (ESC_BYTE ^ ESC_XOR)) begin
              p0v = 1'b1;
              p0  = ESC_BYTE;
            end else begin
              // unknown pair: pass the escape through, then the byte unless it opens a new escape
              p0v = 1'b1;
              p0  = ESC_BYTE;
              if (b == ESC_BYTE) begin
                esc_next = 1'b1;
              end else begin
                p1v = 1'b1;
                p1  = b;
              end
            end
          end else if (b == ESC_BYTE) begin
            esc_next = 1'b1;
          end else begin
            p0v = 1'b1;
            p0  = b;
          end
        end
        ST_SUPV: begin
          if (b == FLAG_BYTE) begin
            if (control_seen == CTL_SET) begin
              res[0] = mk_result(KIND_VERDICT, 8'd0, VERD_SET, 1'b1, CTL_UA);
            end else if (control_seen == CTL_UA) begin
              res[0] = mk_result(KIND_VERDICT, 8'd0, VERD_UA, 1'b0, 8'd0);
            end else begin
              res[0] = mk_result(KIND_VERDICT, 8'd0, VERD_DISC, 1'b0, 8'd0);
            end
            n           = 2'd1;
            tcount_next = '0;
          end
          hunt_next = ST_WAIT;
        end
        default: begin
          hunt_next = (b == FLAG_BYTE) ? ST_FLAG : ST_WAIT;
        end
      endcase

      // release the held byte ahead of each new one
      if (p0v) begin
        if (held_valid_next) begin
          res[n[0]] = mk_result(KIND_BYTE, held_next, VERD_NEW, 1'b0, 8'd0);
          n         = n + 2'd1;
          chk_next  = chk_next ^ held_next;
          hunt_next = ST_DATA1;
        end
        held_next       = p0;
        held_valid_next = 1'b1;
      end
      if (p1v) begin
        if (held_valid_next) begin
          res[n[0]] = mk_result(KIND_BYTE, held_next, VERD_NEW, 1'b0, 8'd0);
          n         = n + 2'd1;
          chk_next  = chk_next ^ held_next;
          hunt_next = ST_DATA1;
        end
        held_next       = p1;
        held_valid_next = 1'b1;
      end

      if (closing) begin
        ns   = (control_seen == CTL_I1);
        good = (hunt_next == ST_DATA1) && held_valid_next && (held_next == chk_next);
        if (ns != exp_seq) begin
          res[n[0]] = mk_result(KIND_VERDICT, 8'd0, VERD_DUP, 1'b1,
                                exp_seq ? CTL_RR1 : CTL_RR0);
        end else if (good) begin
          res[n[0]]    = mk_result(KIND_VERDICT, 8'd0, VERD_NEW, 1'b1,
                                   ns ? CTL_RR0 : CTL_RR1);
          exp_seq_next = ~exp_seq;
          tcount_next  = '0;
        end else begin
          res[n[0]] = mk_result(KIND_VERDICT, 8'd0, VERD_BAD, 1'b1,
                                ns ? CTL_REJ1 : CTL_REJ0);
        end
        n               = n + 2'd1;
        hunt_next       = ST_WAIT;
        esc_next        = 1'b0;
        held_next       = '0;
        held_valid_next = 1'b0;
        chk_next        = '0;
      end
    end

    if (n == 2'd2) begin
      res[1].last = 1'b1;
    end else if (n == 2'd1) begin
      res[0].last = 1'b1;
    end
  end

  assign q_wr       = accept && (n != 2'd0);
  assign q_entry.two = n[1];
  assign q_entry.r0  = res[0];
  assign q_entry.r1  = res[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt         <= ST_WAIT;
      control_seen <= '0;
      esc          <= 1'b0;
      held         <= '0;
      held_valid   <= 1'b0;
      chk          <= '0;
      exp_seq      <= 1'b0;
      tcount       <= '0;
    end else if (accept) begin
      hunt         <= hunt_next;
      control_seen <= control_seen_next;
      esc          <= esc_next;
      held         <= held_next;
      held_valid   <= held_valid_next;
      chk          <= chk_next;
      exp_seq      <= exp_seq_next;
      tcount       <= tcount_next;
    end
  end

endmodule : lfr_front
`default_nettype wire

[rtl/core/lfr_queue.sv]
// Short queue of result entries between front and back.
`timescale 1ns / 1ps
`default_nettype none
module lfr_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire lfr_pkg::entry_t wr_entry,
  input  wire logic           rd,
  output lfr_pkg::entry_t     rd_entry,
  output lfr_pkg::q_status_t  stat
);
  import lfr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == DEPTH_CNT);
  assign rd_entry   = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + PW'(1);
      end
      if (rd) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + PW'(1);
      end
      if (wr && !rd) begin
        count <= count + CW'(1);
      end else if (rd && !wr) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr |-> !stat.full || rd)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd |-> !stat.empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_CNT)
    else $error("queue count beyond depth");

endmodule : lfr_queue
`default_nettype wire

[rtl/core/lfr_back.sv]
// Back end: splits queue entries into single results and holds the one on show.
`timescale 1ns / 1ps
`default_nettype none
module lfr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lfr_pkg::q_status_t q_stat,
  input  wire lfr_pkg::entry_t q_entry,
  output logic                q_rd,
  input  wire logic           pop,
  output logic                empty,
  output lfr_pkg::result_t    result
);
  import lfr_pkg::*;

  logic    out_valid, pend_valid;
  result_t pend;
  logic    advance;

  assign empty   = !out_valid;
  assign advance = !out_valid || pop;
  assign q_rd    = advance && !pend_valid && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (advance) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!q_stat.empty) begin
        out_valid  <= 1'b1;
        pend_valid <= q_entry.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers: hold unless advancing
  always_ff @(posedge clk) begin
    if (advance) begin
      if (pend_valid) begin
        result <= pend;
      end else if (!q_stat.empty) begin
        result <= q_entry.r0;
        pend   <= q_entry.r1;
      end
    end
  end

endmodule : lfr_back
`default_nettype wire

[bench/link_frame_receiver_arq_core_tb.sv]
// Self-checking testbench for the link frame receiver core: directed frames, then random line traffic.
`timescale 1ns / 1ps

module link_frame_receiver_arq_core_tb;
  import lfr_pkg::*;

  localparam int IDLE_PCT       = 32;    // chance in a hundred that a side idles in any given cycle
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 300;   // minimum line items per random phase
  localparam int SETTLE_CYCLES  = 4;     // front end finishes in the transfer cycle; allow slack
  localparam int TAIL_CYCLES    = 10;
  // Longest quiet stretch in a correct run is a settling pause plus a run of
  // random stalls on one side.
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [2:0] NO_VERDICT = 3'd0;
  localparam logic [7:0] NO_REPLY   = 8'h00;
  localparam logic [7:0] NO_DATA    = 8'h00;

  // Hunt states of the receiver model
  typedef enum logic [2:0] {
    H_WAIT, H_FLAG, H_ADDR, H_CTRL, H_DATA0, H_SUPV, H_DATA1
  } hunt_e;

  // One row of the directed plan; typed rows carry their own expectation
  typedef struct packed {
    item_t      itm;
    logic       typed;
    logic [1:0] n;
    result_t    e0;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  item_t       line_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  result_t     rx_result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  link_frame_receiver_arq_core u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (line_item),
    .empty   (empty),
    .pop     (pop),
    .result  (rx_result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Receiver model: own copy of the hunt state, frame state and registers
  // ---------------------------------------------------------------------------
  hunt_e      m_hunt = H_WAIT;
  logic [7:0] m_ctl = '0;
  logic       m_esc = 1'b0;
  logic [7:0] m_held = '0;
  logic       m_held_v = 1'b0;
  logic [7:0] m_chk = '0;
  logic       m_seq = 1'b0;
  logic [7:0] m_tmo = '0;
  logic [7:0] m_tries = MAX_TRIES_RESET;
  logic [7:0] m_station = STATION_RESET;

  result_t    out_buf [2];
  int         out_n;

  result_t    due_results [$];   // results still owed by the block, oldest first
  item_t      line_q [$];        // line items of the burst being built
  plan_row_t  plan [$];

  int  errors = 0;
  int  n_items = 0;
  int  n_results = 0;
  int  n_payload = 0;
  int  n_fail = 0;
  int  verdict_tally [6] = '{default: 0};
  int  quiet_cycles = 0;
  logic calm = 1'b0;             // no idling on either side while set

  function automatic result_t mk(input logic [1:0] k, input logic [7:0] d,
                                 input logic [2:0] v, input logic rv,
                                 input logic [7:0] rc, input logic l);
    result_t r;
    r.kind = k;
    r.data_byte = d;
    r.verdict = v;
    r.reply_valid = rv;
    r.reply_control = rc;
    r.last = l;
    return r;
  endfunction

  task automatic emit(input logic [1:0] k, input logic [7:0] d, input logic [2:0] v,
                      input logic rv, input logic [7:0] rc);
    out_buf[out_n] = mk(k, d, v, rv, rc, 1'b0);
    out_n++;
  endtask

  task automatic clear_frame();
    m_esc = 1'b0;
    m_held = '0;
    m_held_v = 1'b0;
    m_chk = '0;
  endtask

  // Release the held byte, if any, and hold the new one in its place
  task automatic hold_byte(input logic [7:0] d);
    if (m_held_v) begin
      emit(KIND_BYTE, m_held, NO_VERDICT, 1'b0, NO_REPLY);
      m_chk = m_chk ^ m_held;
      m_hunt = H_DATA1;
    end
    m_held = d;
    m_held_v = 1'b1;
  endtask

  task automatic step_receiver(input item_t it, output int n, output result_t r0,
                               output result_t r1);
    logic [7:0] b;
    logic       ns;
    logic       good;
    logic [2:0] v;
    logic [7:0] rc;
    b = it.rx_byte;
    out_n = 0;
    if (it.mode == MODE_TICK) begin
      // drop any partial frame and count the tick
      m_hunt = H_WAIT;
      clear_frame();
      m_tmo = m_tmo + 8'd1;
      if (m_tmo >= m_tries) begin
        m_tmo = '0;
        emit(KIND_FAIL, NO_DATA, NO_VERDICT, 1'b0, NO_REPLY);
      end
    end else begin
      case (m_hunt)
        H_FLAG: begin
          if (b == m_station) m_hunt = H_ADDR;
          else if (b != FLAG_BYTE) m_hunt = H_WAIT;
        end
        H_ADDR: begin
          if (b == CTL_I0 || b == CTL_I1 || b == CTL_SET || b == CTL_UA || b == CTL_DISC) begin
            m_ctl = b;
            m_hunt = H_CTRL;
          end else begin
            m_hunt = (b == FLAG_BYTE) ? H_FLAG : H_WAIT;
          end
        end
        H_CTRL: begin
          if (b == (m_station ^ m_ctl)) begin
            clear_frame();
            m_hunt = (m_ctl == CTL_I0 || m_ctl == CTL_I1) ? H_DATA0 : H_SUPV;
          end else begin
            m_hunt = (b == FLAG_BYTE) ? H_FLAG : H_WAIT;
          end
        end
        H_DATA0, H_DATA1: begin
          if (b == FLAG_BYTE) begin
            // closing flag: a pending escape goes out as a literal first
            if (m_esc) begin
              m_esc = 1'b0;
              hold_byte(ESC_BYTE);
            end
            ns = (m_ctl == CTL_I1);
            good = (m_hunt == H_DATA1) && m_held_v && (m_held == m_chk);
            if (ns != m_seq) begin
              v = VERD_DUP;
              rc = m_seq ? CTL_RR1 : CTL_RR0;
            end else if (good) begin
              v = VERD_NEW;
              rc = ns ? CTL_RR0 : CTL_RR1;
              m_seq = ~m_seq;
              m_tmo = '0;
            end else begin
              v = VERD_BAD;
              rc = ns ? CTL_REJ1 : CTL_REJ0;
            end
            emit(KIND_VERDICT, NO_DATA, v, 1'b1, rc);
            m_hunt = H_WAIT;
            clear_frame();
          end else if (m_esc) begin
            m_esc = 1'b0;
            if (b == (FLAG_BYTE ^ ESC_XOR)) begin
              hold_byte(FLAG_BYTE);
            end else if (b == (ESC_BYTE ^ ESC_XOR)) begin
              hold_byte(ESC_BYTE);
            end else begin
              // unknown pair: the escape passes as a literal
              hold_byte(ESC_BYTE);
              if (b == ESC_BYTE) m_esc = 1'b1;
              else hold_byte(b);
            end
          end else if (b == ESC_BYTE) begin
            m_esc = 1'b1;
          end else begin
            hold_byte(b);
          end
        end
        H_SUPV: begin
          if (b == FLAG_BYTE) begin
            if (m_ctl == CTL_SET) emit(KIND_VERDICT, NO_DATA, VERD_SET, 1'b1, CTL_UA);
            else if (m_ctl == CTL_UA) emit(KIND_VERDICT, NO_DATA, VERD_UA, 1'b0, NO_REPLY);
            else emit(KIND_VERDICT, NO_DATA, VERD_DISC, 1'b0, NO_REPLY);
            m_tmo = '0;
          end
          m_hunt = H_WAIT;
        end
        default: m_hunt = (b == FLAG_BYTE) ? H_FLAG : H_WAIT;
      endcase
    end
    if (out_n > 0) out_buf[out_n - 1].last = 1'b1;
    n = out_n;
    r0 = out_buf[0];
    r1 = out_buf[1];
  endtask

  // ---------------------------------------------------------------------------
  // Reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic report(input string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Sample at the rising edge: compare each result transfer with the oldest
  // expectation and keep the watchdog fed by any transfer or register access.
  result_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty) || psel) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results owed",
                 quiet_cycles, due_results.size());
        $display("tb: failure");
        $finish;
      end
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          report($sformatf("result with nothing expected: kind %0d data %02h",
                           rx_result.kind, rx_result.data_byte));
        end else begin
          want = due_results.pop_front();
          n_results++;
          if (rx_result.kind !== want.kind)
            report($sformatf("kind got %0d want %0d", rx_result.kind, want.kind));
          if (rx_result.data_byte !== want.data_byte)
            report($sformatf("data_byte got %02h want %02h", rx_result.data_byte,
                             want.data_byte));
          if (rx_result.verdict !== want.verdict)
            report($sformatf("verdict got %0d want %0d", rx_result.verdict, want.verdict));
          if (rx_result.reply_valid !== want.reply_valid)
            report($sformatf("reply_valid got %0b want %0b", rx_result.reply_valid,
                             want.reply_valid));
          if (rx_result.reply_control !== want.reply_control)
            report($sformatf("reply_control got %02h want %02h", rx_result.reply_control,
                             want.reply_control));
          if (rx_result.last !== want.last)
            report($sformatf("last got %0b want %0b", rx_result.last, want.last));
          if (want.kind == KIND_BYTE) n_payload++;
          else if (want.kind == KIND_FAIL) n_fail++;
          else if (want.verdict <= VERD_DISC) verdict_tally[want.verdict]++;
        end
      end
    end
  end

  // Result side: stall at random, except through the calm stretch
  always @(negedge clk) pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

  // ---------------------------------------------------------------------------
  // Item side and register port
  // ---------------------------------------------------------------------------

  // Enter and leave at a falling edge. Idle at random, then hold the item
  // until its transfer and log what it must produce.
  task automatic send_item(input item_t it, input logic typed, input logic [1:0] tn,
                           input result_t te);
    int      n;
    result_t r0;
    result_t r1;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    line_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    step_receiver(it, n, r0, r1);
    if (typed) begin
      if (tn != 0) due_results.push_back(te);
    end else begin
      if (n > 0) due_results.push_back(r0);
      if (n > 1) due_results.push_back(r1);
    end
    n_items++;
    @(negedge clk);
  endtask

  // Hold the sender until every owed result has left, then let the block settle
  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write one register, then read it back
  task automatic write_reg(input logic idx, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_MAX_TRIES) m_tries = val;
    else m_station = val;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {24'd0, val})
      report($sformatf("register %0d read %08h want %08h", idx, prdata, {24'd0, val}));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic plan_byte(input logic [7:0] b);
    plan_row_t row;
    row = '0;
    row.itm.mode = MODE_BYTE;
    row.itm.rx_byte = b;
    plan.push_back(row);
  endtask

  task automatic plan_typed(input logic mode, input logic [7:0] b, input logic [1:0] n,
                            input result_t e);
    plan_row_t row;
    row.itm.mode = mode;
    row.itm.rx_byte = b;
    row.typed = 1'b1;
    row.n = n;
    row.e0 = e;
    plan.push_back(row);
  endtask

  task automatic add_byte(input logic [7:0] b);
    item_t it;
    it.mode = MODE_BYTE;
    it.rx_byte = b;
    line_q.push_back(it);
  endtask

  // Stuff a payload byte the way a well-behaved sender would
  task automatic add_stuffed(input logic [7:0] p);
    if (p == FLAG_BYTE || p == ESC_BYTE) begin
      add_byte(ESC_BYTE);
      add_byte(p ^ ESC_XOR);
    end else begin
      add_byte(p);
    end
  endtask

  task automatic add_header(input logic [7:0] ctl);
    add_byte(FLAG_BYTE);
    add_byte(m_station);
    add_byte(ctl);
    add_byte(m_station ^ ctl);
  endtask

  // Lean towards the bytes that matter to framing
  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 9))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      2: return FLAG_BYTE ^ ESC_XOR;
      3: return ESC_BYTE ^ ESC_XOR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Build one burst of line traffic: mostly well-formed frames with random
  // content, with ticks, broken headers and loose bytes mixed in.
  task automatic build_burst();
    int         pick;
    int         len;
    int         pos;
    logic       ns;
    logic [7:0] ctl;
    logic [7:0] chk;
    logic [7:0] p;
    logic [7:0] hdr [4];
    item_t      tk;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // data frame, mostly with the expected sequence bit
      ns = ($urandom_range(0, 3) == 0) ? ~m_seq : m_seq;
      ctl = ns ? CTL_I1 : CTL_I0;
      add_header(ctl);
      len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
      chk = 8'h00;
      for (int i = 0; i < len; i++) begin
        p = pick_payload();
        chk = chk ^ p;
        add_stuffed(p);
        // now and then a raw escape with whatever follows it
        if ($urandom_range(0, 19) == 0) begin
          add_byte(ESC_BYTE);
          add_byte(8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 7) == 0) chk = chk ^ (8'h01 << $urandom_range(0, 7));
      if (len > 0 || $urandom_range(0, 1) == 1) add_stuffed(chk);
      if ($urandom_range(0, 15) == 0) add_byte(ESC_BYTE);  // escape left open at the flag
      add_byte(FLAG_BYTE);
    end else if (pick < 70) begin
      // supervisory frame, sometimes with a stray byte before the flag
      case ($urandom_range(0, 2))
        0: ctl = CTL_SET;
        1: ctl = CTL_UA;
        default: ctl = CTL_DISC;
      endcase
      add_header(ctl);
      if ($urandom_range(0, 7) == 0) add_byte(8'($urandom_range(0, 255)));
      add_byte(FLAG_BYTE);
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 3)) begin
        tk.mode = MODE_TICK;
        tk.rx_byte = 8'($urandom_range(0, 255));
        line_q.push_back(tk);
      end
    end else if (pick < 90) begin
      // header with one byte spoilt, often by a flag inside it
      case ($urandom_range(0, 4))
        0: ctl = CTL_I0;
        1: ctl = CTL_I1;
        2: ctl = CTL_SET;
        3: ctl = CTL_UA;
        default: ctl = CTL_DISC;
      endcase
      hdr[0] = FLAG_BYTE;
      hdr[1] = m_station;
      hdr[2] = ctl;
      hdr[3] = m_station ^ ctl;
      pos = $urandom_range(1, 3);
      hdr[pos] = ($urandom_range(0, 1) == 1) ? FLAG_BYTE : 8'($urandom_range(0, 255));
      for (int i = 0; i < 4; i++) add_byte(hdr[i]);
      repeat ($urandom_range(0, 3)) add_byte(pick_payload());
      add_byte(FLAG_BYTE);
    end else begin
      repeat ($urandom_range(1, 4)) add_byte(pick_payload());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int         phase_start;
    logic [7:0] tries;
    logic [7:0] station;
    plan_row_t  row;

    // Directed plan at the reset settings (limit 3, station 1).
    // Three ticks: the third reaches the limit.
    plan_typed(MODE_TICK, 8'h00, 2'd0, '0);
    plan_typed(MODE_TICK, 8'hff, 2'd0, '0);
    plan_typed(MODE_TICK, 8'h5a, 2'd1,
               mk(KIND_FAIL, NO_DATA, NO_VERDICT, 1'b0, NO_REPLY, 1'b1));
    // SET frame answered by UA
    plan_byte(FLAG_BYTE);
    plan_byte(STATION_RESET);
    plan_byte(CTL_SET);
    plan_byte(STATION_RESET ^ CTL_SET);
    plan_typed(MODE_BYTE, FLAG_BYTE, 2'd1,
               mk(KIND_VERDICT, NO_DATA, VERD_SET, 1'b1, CTL_UA, 1'b1));
    // I0 frame: stuffed flag, an unknown pair whose second byte opens a new
    // escape, a stuffed escape, and a stuffed check byte
    plan_byte(FLAG_BYTE);
    plan_byte(STATION_RESET);
    plan_byte(CTL_I0);
    plan_byte(STATION_RESET ^ CTL_I0);
    plan_byte(ESC_BYTE);
    plan_byte(FLAG_BYTE ^ ESC_XOR);
    plan_byte(ESC_BYTE);
    plan_byte(ESC_BYTE);
    plan_byte(ESC_BYTE ^ ESC_XOR);
    plan_byte(ESC_BYTE);
    plan_byte(FLAG_BYTE ^ ESC_XOR);
    plan_byte(FLAG_BYTE);
    // Empty I1 frame straight after the closing flag: rejected
    plan_byte(FLAG_BYTE);
    plan_byte(STATION_RESET);
    plan_byte(CTL_I1);
    plan_byte(STATION_RESET ^ CTL_I1);
    plan_typed(MODE_BYTE, FLAG_BYTE, 2'd1,
               mk(KIND_VERDICT, NO_DATA, VERD_BAD, 1'b1, CTL_REJ1, 1'b1));

    // Hold reset, then release it at a falling edge
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      send_item(row.itm, row.typed, row.n, row.e0);
    end

    // Random phases, each under its own register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin tries = 8'd1;   station = 8'h00; end
        1: begin tries = 8'd255; station = 8'hff; end
        2: begin tries = 8'd0;   station = FLAG_BYTE; end
        3: begin tries = 8'($urandom_range(1, 8)); station = ESC_BYTE; end
        4: begin tries = 8'd2;   station = 8'($urandom_range(0, 255)); end
        default: begin tries = MAX_TRIES_RESET; station = STATION_RESET; end
      endcase
      write_reg(REG_MAX_TRIES, tries);
      write_reg(REG_STATION, station);
      calm = (ph == 1);   // the long stretch with no idling on either side
      phase_start = n_items;
      while (n_items - phase_start < PHASE_ITEMS) begin
        build_burst();
        while (line_q.size() != 0) send_item(line_q.pop_front(), 1'b0, 2'd0, '0);
        // now and then hold the sender until the block has caught up
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (due_results.size() != 0)
      report($sformatf("%0d results never arrived", due_results.size()));

    $display("run: %0d line items, %0d results (%0d payload bytes, %0d timeout failures)",
             n_items, n_results, n_payload, n_fail);
    $display("run: verdicts new %0d dup %0d bad %0d set %0d ua %0d disc %0d, %0d mismatches",
             verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
             verdict_tally[4], verdict_tally[5], errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
